// ----- design/mfpdr_pkg.sv -----
// Shared constants and types for the marker frame delivery-ratio monitor.
// Used by mfpdr_framer, mfpdr_divider and marker_frame_pdr_monitor.
package mfpdr_pkg;

  localparam int MaxPayload = 250;
  localparam int CountWidth = 32;
  localparam int RatioWidth = 20;
  localparam int SeqWidth = 8;
  localparam int ByteWidth = 8;
  localparam int ScaleWidth = 14;
  localparam int DividendWidth = CountWidth + ScaleWidth;
  localparam int DivCntWidth = $clog2(DividendWidth + 1);

  localparam logic [ByteWidth-1:0] SyncMark = 8'h7E;
  localparam logic [ByteWidth-1:0] PayloadReset = 8'd32;
  localparam logic [ScaleWidth-1:0] RatioScale = 14'd10000;
  localparam logic [RatioWidth-1:0] RatioMax = {RatioWidth{1'b1}};
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  // Frame completion report from the framer to the top level.
  typedef struct packed {
    logic                 done;
    logic [SeqWidth-1:0]  seq;
    logic [ByteWidth-1:0] rssi;
  } frame_info_t;

endpackage

// ----- design/mfpdr_framer.sv -----
// Marker hunt and fixed-length frame tracking, one byte per transfer.
// Depends on mfpdr_pkg for widths, the marker value and frame_info_t.
module mfpdr_framer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           byte_take,
  input  logic [mfpdr_pkg::ByteWidth-1:0] rx_byte,
  input  logic [mfpdr_pkg::ByteWidth-1:0] payload_length,
  output mfpdr_pkg::frame_info_t         info
);

  logic                            synced;
  logic [mfpdr_pkg::ByteWidth-1:0] byte_position;
  logic [mfpdr_pkg::SeqWidth-1:0]  frame_sequence;

  logic [mfpdr_pkg::ByteWidth-1:0] payload_clamped;
  logic [mfpdr_pkg::ByteWidth-1:0] frame_len;
  logic [mfpdr_pkg::ByteWidth-1:0] position_next;
  logic [mfpdr_pkg::SeqWidth-1:0]  seq_cur;
  logic                            last_byte;

  always_comb begin
    if (payload_length == '0) begin
      payload_clamped = mfpdr_pkg::ByteWidth'(1);
    end else if (payload_length > mfpdr_pkg::ByteWidth'(mfpdr_pkg::MaxPayload)) begin
      payload_clamped = mfpdr_pkg::ByteWidth'(mfpdr_pkg::MaxPayload);
    end else begin
      payload_clamped = payload_length;
    end
    frame_len     = payload_clamped + mfpdr_pkg::ByteWidth'(3);
    position_next = byte_position + mfpdr_pkg::ByteWidth'(1);
    seq_cur       = (byte_position == mfpdr_pkg::ByteWidth'(1)) ? rx_byte : frame_sequence;
    last_byte     = (position_next == '0) || (position_next >= frame_len);
  end

  assign info.done = byte_take && synced && last_byte;
  assign info.seq  = seq_cur;
  assign info.rssi = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      synced         <= 1'b0;
      byte_position  <= '0;
      frame_sequence <= '0;
    end else if (byte_take) begin
      if (!synced) begin
        // drop everything but the marker
        if (rx_byte == mfpdr_pkg::SyncMark) begin
          synced        <= 1'b1;
          byte_position <= mfpdr_pkg::ByteWidth'(1);
        end
      end else begin
        frame_sequence <= seq_cur;
        if (last_byte) begin
          synced        <= 1'b0;
          byte_position <= '0;
        end else begin
          byte_position <= position_next;
        end
      end
    end
  end

endmodule

// ----- design/mfpdr_divider.sv -----
// Bit-serial restoring divider, one quotient bit per cycle, saturating quotient.
// Depends on mfpdr_pkg for dividend and quotient widths.
module mfpdr_divider (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [mfpdr_pkg::DividendWidth-1:0] dividend,
  input  logic [mfpdr_pkg::SeqWidth:0]       divisor,
  input  logic                               take,
  output logic                               busy,
  output logic                               done,
  output logic [mfpdr_pkg::RatioWidth-1:0]   quotient
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]                         state;
  logic [mfpdr_pkg::DividendWidth-1:0] num;
  logic [mfpdr_pkg::SeqWidth:0]       den;
  logic [mfpdr_pkg::SeqWidth-1:0]     rem;
  logic [mfpdr_pkg::RatioWidth-1:0]   quo;
  logic                               ovf;
  logic [mfpdr_pkg::DivCntWidth-1:0]  cnt;

  logic [mfpdr_pkg::SeqWidth+1:0]     trial;
  logic                               fits;
  logic [mfpdr_pkg::SeqWidth+1:0]     trial_sub;

  always_comb begin
    trial     = {1'b0, rem, num[mfpdr_pkg::DividendWidth-1]};
    fits      = trial >= {1'b0, den};
    trial_sub = trial - {1'b0, den};
  end

  assign busy     = state != StIdle;
  assign done     = state == StDone;
  assign quotient = ovf ? mfpdr_pkg::RatioMax : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      cnt   <= '0;
    end else begin
      case (state)
        StIdle: begin
          if (start) begin
            state <= StRun;
            cnt   <= mfpdr_pkg::DivCntWidth'(mfpdr_pkg::DividendWidth);
          end
        end
        StRun: begin
          cnt <= cnt - mfpdr_pkg::DivCntWidth'(1);
          if (cnt == mfpdr_pkg::DivCntWidth'(1)) begin
            state <= StDone;
          end
        end
        StDone: begin
          if (take) begin
            state <= StIdle;
          end
        end
        default: begin
          state <= StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == StIdle && start) begin
      num <= dividend;
      den <= divisor;
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
    end else if (state == StRun) begin
      num <= {num[mfpdr_pkg::DividendWidth-2:0], 1'b0};
      rem <= fits ? trial_sub[mfpdr_pkg::SeqWidth-1:0] : trial[mfpdr_pkg::SeqWidth-1:0];
      quo <= {quo[mfpdr_pkg::RatioWidth-2:0], fits};
      ovf <= ovf | quo[mfpdr_pkg::RatioWidth-1];
    end
  end

endmodule

// ----- design/marker_frame_pdr_monitor.sv -----
// Marker-synced frame receiver with frame counter and delivery ratio output.
// Bytes that do not end a frame are taken whenever no division is in flight.
// The last byte of a frame starts a bit-serial divider that steps through the
// 46 dividend bits in turn; the result then moves to the output register once
// that register is free, and only after that move is the next byte taken.
// Sync active-high reset: hunting, counters cleared, payload length 32.
module marker_frame_pdr_monitor (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mfpdr_pkg::ByteWidth-1:0]     payload_length,
  // byte input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mfpdr_pkg::ByteWidth-1:0]     rx_byte,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mfpdr_pkg::SeqWidth-1:0]      sequence_res,
  output logic [mfpdr_pkg::ByteWidth-1:0]     rssi_raw,
  output logic [mfpdr_pkg::ByteWidth:0]       loss_db,
  output logic [mfpdr_pkg::CountWidth-1:0]    received_total,
  output logic [mfpdr_pkg::SeqWidth:0]        expected_total,
  output logic [mfpdr_pkg::RatioWidth-1:0]    ratio_hundredths
);

  logic [mfpdr_pkg::ByteWidth-1:0] payload_reg;

  logic [mfpdr_pkg::CountWidth-1:0] frame_count;
  logic [mfpdr_pkg::SeqWidth-1:0]   highest_sequence;

  // values of the frame under division, held until moved to the outputs
  logic [mfpdr_pkg::SeqWidth-1:0]   seq_hold;
  logic [mfpdr_pkg::ByteWidth-1:0]  rssi_hold;
  logic [mfpdr_pkg::CountWidth-1:0] total_hold;
  logic [mfpdr_pkg::SeqWidth:0]     expected_hold;

  mfpdr_pkg::frame_info_t           info;
  logic                             byte_take;
  logic [mfpdr_pkg::CountWidth-1:0] frame_count_next;
  logic [mfpdr_pkg::SeqWidth-1:0]   highest_next;
  logic [mfpdr_pkg::SeqWidth:0]     expected_next;
  logic [mfpdr_pkg::DividendWidth-1:0] scaled_count;

  logic                             div_busy;
  logic                             div_done;
  logic                             div_take;
  logic [mfpdr_pkg::RatioWidth-1:0] div_quotient;

  // Configuration is always taken; hold the register until the next write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_reg <= mfpdr_pkg::PayloadReset;
    end else if (cfg_valid) begin
      payload_reg <= payload_length;
    end
  end

  // Bytes are taken whenever no ratio computation is in flight; a result
  // parked in the output register does not stall bytes that end no frame.
  assign in_ready  = !div_busy;
  assign byte_take = in_valid && in_ready;

  mfpdr_framer u_framer (
    .clk            (clk),
    .rst            (rst),
    .byte_take      (byte_take),
    .rx_byte        (rx_byte),
    .payload_length (payload_reg),
    .info           (info)
  );

  always_comb begin
    frame_count_next = (frame_count != mfpdr_pkg::CountMax)
                       ? frame_count + mfpdr_pkg::CountWidth'(1) : frame_count;
    highest_next     = (info.seq > highest_sequence) ? info.seq : highest_sequence;
    expected_next    = {1'b0, highest_next} + (mfpdr_pkg::SeqWidth + 1)'(1);
    // count * 10000 is a constant multiply; the product lands in the divider's
    // shift register
    scaled_count     = mfpdr_pkg::DividendWidth'(frame_count_next)
                       * mfpdr_pkg::DividendWidth'(mfpdr_pkg::RatioScale);
  end

  // Advance the counters and capture the frame fields on its last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count      <= '0;
      highest_sequence <= '0;
    end else if (info.done) begin
      frame_count      <= frame_count_next;
      highest_sequence <= highest_next;
    end
  end

  always_ff @(posedge clk) begin
    if (info.done) begin
      seq_hold      <= info.seq;
      rssi_hold     <= info.rssi;
      total_hold    <= frame_count_next;
      expected_hold <= expected_next;
    end
  end

  mfpdr_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (info.done),
    .dividend (scaled_count),
    .divisor  (expected_next),
    .take     (div_take),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Move a finished result into the output register once it is free.
  assign div_take = div_done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (div_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_take) begin
      sequence_res     <= seq_hold;
      rssi_raw         <= rssi_hold;
      loss_db          <= (mfpdr_pkg::ByteWidth + 1)'(256) - {1'b0, rssi_hold};
      received_total   <= total_hold;
      expected_total   <= expected_hold;
      ratio_hundredths <= div_quotient;
    end
  end

endmodule

// ----- dv/marker_frame_pdr_monitor_tb.sv -----
// Self-checking testbench for marker_frame_pdr_monitor: drives bytes and length writes,
// predicts every frame report and checks each field. Depends on mfpdr_pkg
// and the marker_frame_pdr_monitor RTL.
module testbench;

  localparam int unsigned ResetCycles = 12;
  // Leave margin for the divider to finish each frame before a length write.
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned LongHold = 600;
  localparam int unsigned CycleLimit = 400000;
  localparam logic [mfpdr_pkg::ByteWidth-1:0] Marker = 8'h7E;
  localparam int unsigned PayloadCap = 250;
  localparam longint unsigned RatioCeil = 1048575;
  localparam longint unsigned RatioScaleVal = 10000;

  // One frame report as it leaves the result channel.
  typedef struct packed {
    logic [mfpdr_pkg::SeqWidth-1:0]   seq;
    logic [mfpdr_pkg::ByteWidth-1:0]  rssi;
    logic [mfpdr_pkg::ByteWidth:0]    loss;
    logic [mfpdr_pkg::CountWidth-1:0] total;
    logic [mfpdr_pkg::SeqWidth:0]     expected;
    logic [mfpdr_pkg::RatioWidth-1:0] ratio;
  } frame_report_t;

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [mfpdr_pkg::ByteWidth-1:0]  payload_length = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [mfpdr_pkg::ByteWidth-1:0]  rx_byte = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [mfpdr_pkg::SeqWidth-1:0]   sequence_res;
  logic [mfpdr_pkg::ByteWidth-1:0]  rssi_raw;
  logic [mfpdr_pkg::ByteWidth:0]    loss_db;
  logic [mfpdr_pkg::CountWidth-1:0] received_total;
  logic [mfpdr_pkg::SeqWidth:0]     expected_total;
  logic [mfpdr_pkg::RatioWidth-1:0] ratio_hundredths;

  marker_frame_pdr_monitor u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .payload_length   (payload_length),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .sequence_res     (sequence_res),
    .rssi_raw         (rssi_raw),
    .loss_db          (loss_db),
    .received_total   (received_total),
    .expected_total   (expected_total),
    .ratio_hundredths (ratio_hundredths)
  );

  // Frame tracker: our own copy of the receiver state and the length register.
  logic                             trk_synced;
  logic [mfpdr_pkg::ByteWidth-1:0]  trk_pos;
  logic [mfpdr_pkg::SeqWidth-1:0]   trk_seq;
  logic [mfpdr_pkg::CountWidth-1:0] trk_count;
  logic [mfpdr_pkg::SeqWidth-1:0]   trk_highest;
  logic [mfpdr_pkg::ByteWidth-1:0]  trk_payload_len;
  frame_report_t                    pending_reports[$];

  // Stimulus queues and handshake bookkeeping.
  logic [mfpdr_pkg::ByteWidth-1:0]  byte_q[$];
  logic [mfpdr_pkg::ByteWidth-1:0]  cfg_q[$];
  int unsigned                      bytes_queued = 0;
  int unsigned                      cfg_writes = 0;
  int unsigned                      burst_left = 0;
  int unsigned                      gap_left = 0;
  logic [mfpdr_pkg::SeqWidth-1:0]   seq_next = 8'd1;
  int unsigned                      fails = 0;
  int unsigned                      cycle_cnt = 0;

  // Receiver stall pattern and the one long hold-off.
  logic [7:0]            stall_pat;
  int unsigned           pat_age;
  logic                  hold_req = 1'b0;
  logic                  hold_spent = 1'b0;
  int unsigned           hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Clamp the length register the way the block does: zero means one byte,
  // anything above the payload limit is cut back to the limit.
  function automatic int unsigned eff_payload(input logic [mfpdr_pkg::ByteWidth-1:0] v);
    if (v == '0) return 1;
    if (v > PayloadCap) return PayloadCap;
    return v;
  endfunction

  // Advance the frame tracker by one accepted byte; on the last byte of a
  // frame, queue the report the block must produce.
  function automatic void track_byte(input logic [mfpdr_pkg::ByteWidth-1:0] b);
    int unsigned     flen;
    longint unsigned cnt;
    longint unsigned exp_total;
    longint unsigned ratio;
    frame_report_t   rep;
    if (!trk_synced) begin
      // Hunting: drop everything but the marker.
      if (b == Marker) begin
        trk_synced = 1'b1;
        trk_pos = 8'd1;
      end
      return;
    end
    if (trk_pos == 8'd1) trk_seq = b;
    trk_pos = trk_pos + 8'd1;
    // The length in force now decides; a shorter length written mid-frame
    // makes the very next byte the last one.
    flen = eff_payload(trk_payload_len) + 3;
    if (trk_pos != '0 && trk_pos < flen) return;
    if (trk_count != mfpdr_pkg::CountMax) trk_count = trk_count + 1'b1;
    if (trk_seq > trk_highest) trk_highest = trk_seq;
    cnt = trk_count;
    exp_total = longint'(trk_highest) + 1;
    ratio = (cnt * RatioScaleVal) / exp_total;
    if (ratio > RatioCeil) ratio = RatioCeil;
    rep.seq = trk_seq;
    rep.rssi = b;
    rep.loss = 9'(256 - int'(b));
    rep.total = trk_count;
    rep.expected = 9'(exp_total);
    rep.ratio = mfpdr_pkg::RatioWidth'(ratio);
    pending_reports.push_back(rep);
    trk_synced = 1'b0;
    trk_pos = '0;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // Driver: feeds bytes in bursts with random gaps, and length writes when asked.
  // Acceptance is judged on the values seen at the edge, before this edge's updates.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      rx_byte <= '0;
      payload_length <= '0;
      trk_synced = 1'b0;
      trk_pos = '0;
      trk_seq = '0;
      trk_count = '0;
      trk_highest = '0;
      trk_payload_len = mfpdr_pkg::PayloadReset;
    end else begin
      if (cfg_valid && cfg_ready) begin
        trk_payload_len = payload_length;
        cfg_writes++;
      end
      if (in_valid && in_ready) track_byte(rx_byte);

      // Hold valid and the byte until the transfer completes; only then advance.
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          rx_byte <= byte_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            // Long back-to-back run with no idling.
            burst_left = $urandom_range(30, 80);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end

      if (!cfg_valid || cfg_ready) begin
        if (cfg_q.size() != 0) begin
          payload_length <= cfg_q.pop_front();
          cfg_valid <= 1'b1;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off: once requested, keep the receiver stalled for a fixed count.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_spent <= 1'b0;
    end else if (hold_req && !hold_spent) begin
      hold_left <= LongHold;
      hold_spent <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each result transfer against the oldest queued report,
  // and drive ready from a rotating stall pattern reloaded whenever pat_age wraps.
  always @(posedge clk) begin
    frame_report_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_pat = 8'hFF;
      pat_age = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          $error("result with no frame pending: sequence_res %0d", sequence_res);
          fails++;
        end else begin
          want = pending_reports.pop_front();
          check_field("sequence_res", want.seq, sequence_res);
          check_field("rssi_raw", want.rssi, rssi_raw);
          check_field("loss_db", want.loss, loss_db);
          check_field("received_total", want.total, received_total);
          check_field("expected_total", want.expected, expected_total);
          check_field("ratio_hundredths", want.ratio, ratio_hundredths);
        end
      end
      if (pat_age == 31) begin
        pat_age = 0;
        // A third of the windows never stall.
        stall_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end else begin
        pat_age++;
      end
      stall_pat = {stall_pat[0], stall_pat[7:1]};
      out_ready <= (hold_left == 0) && stall_pat[0];
    end
  end

  task automatic queue_byte(input logic [mfpdr_pkg::ByteWidth-1:0] b);
    byte_q.push_back(b);
    bytes_queued++;
  endtask

  // Random bytes between frames; without markers they are dropped while hunting.
  task automatic queue_noise(input int unsigned n, input bit with_marker);
    logic [mfpdr_pkg::ByteWidth-1:0] b;
    repeat (n) begin
      b = 8'($urandom);
      if (!with_marker && b == Marker) b = 8'h00;
      queue_byte(b);
    end
  endtask

  task automatic queue_frame(input logic [mfpdr_pkg::SeqWidth-1:0] seq,
                             input logic [mfpdr_pkg::ByteWidth-1:0] rssi,
                             input int unsigned npay);
    queue_byte(Marker);
    queue_byte(seq);
    repeat (npay) queue_byte(8'($urandom));
    queue_byte(rssi);
  endtask

  // Wait until every byte is through and every report has arrived, then let
  // the divider settle so a length write finds the block idle.
  task automatic wait_idle();
    wait (byte_q.size() == 0 && !in_valid && pending_reports.size() == 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_len(input logic [mfpdr_pkg::ByteWidth-1:0] v);
    int unsigned seen;
    seen = cfg_writes;
    cfg_q.push_back(v);
    wait (cfg_writes != seen);
  endtask

  // Mostly well-formed frames with mostly rising sequence numbers; the rest
  // are cut-short frames and marker-bearing noise that knock framing off.
  task automatic random_phase(input int unsigned budget, input int unsigned min_frames);
    int unsigned npay;
    int unsigned start;
    int unsigned frames;
    int unsigned pick;
    npay = eff_payload(trk_payload_len);
    start = bytes_queued;
    frames = 0;
    while (bytes_queued - start < budget || frames < min_frames) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        queue_noise($urandom_range(0, 2), 1'b0);
        queue_frame(seq_next, 8'($urandom), npay);
        frames++;
        if ($urandom_range(0, 7) == 0) seq_next = seq_next + 8'($urandom_range(2, 6));
        else seq_next = seq_next + 8'd1;
      end else if (pick == 8) begin
        queue_byte(Marker);
        queue_byte(seq_next);
        repeat ($urandom_range(0, npay)) queue_byte(8'($urandom));
      end else begin
        queue_noise($urandom_range(1, 6), 1'b1);
      end
    end
  endtask

  initial begin
    logic [mfpdr_pkg::ByteWidth-1:0] lens[6];
    lens = '{8'd32, 8'd0, 8'd3, 8'd0, 8'd1, 8'd0};
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    // Hunting drops non-marker bytes; then one frame at the reset length
    // with a marker value inside the payload and the weakest signal.
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h55);
    queue_byte(Marker);
    queue_byte(8'h00);
    queue_byte(Marker);
    repeat (31) queue_byte(8'($urandom));
    queue_byte(8'h00);
    wait_idle();

    // Zero length behaves as one payload byte; strongest signal.
    write_len(8'd0);
    queue_frame(8'h00, 8'hFF, 1);
    wait_idle();

    // Many frames with sequence 0 keep expected at 1 and drive the ratio
    // into saturation.
    write_len(8'd1);
    repeat (110) begin
      queue_noise($urandom_range(0, 1), 1'b0);
      queue_frame(8'h00, 8'($urandom), 1);
    end
    wait_idle();

    // Leave a frame open, then shorten the length below the current position:
    // the next byte must close it.
    write_len(8'd8);
    queue_byte(Marker);
    queue_byte(seq_next);
    repeat (6) queue_byte(8'($urandom));
    seq_next = seq_next + 8'd1;
    wait_idle();
    write_len(8'd2);

    foreach (lens[i]) begin
      if (i != 0) begin
        wait_idle();
        write_len(lens[i] == 8'd0 ? 8'($urandom_range(1, 12)) : lens[i]);
      end
      // Stall the receiver for a long stretch while bytes keep coming.
      if (i == 2) hold_req <= 1'b1;
      random_phase(70, 2);
    end

    // Largest frames: the limit itself, and a value above it that is clamped.
    wait_idle();
    write_len(8'd250);
    queue_noise(3, 1'b0);
    queue_frame(Marker, 8'($urandom), 250);
    wait_idle();
    write_len(8'd255);
    queue_frame(8'hFF, 8'($urandom), 250);

    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (fails == 0 && pending_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog on total run length.
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

endmodule
